@@ design/rmc_pkg.sv @@
// Package for the RMC local-time parser: parser state and sentence summary types,
// character codes and time-zone constants.
// Depends on nothing; used by the top level, rmc_parse, rmc_hour and the testbench.
`default_nettype none

package rmc_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_UPPER_G = 8'h47;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_UPPER_P = 8'h50;
    localparam logic [7:0] CH_UPPER_R = 8'h52;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    localparam logic [3:0] FLD_HEADER = 4'd0;
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_MAX    = 4'd15;

    localparam int unsigned LON_MAX   = 18000;
    localparam int unsigned ZONE_HALF = 750;
    localparam int unsigned ZONE_STEP = 1500;
    localparam int unsigned ZONE_MAX  = 12;
    localparam int unsigned HOURS_DAY = 24;

    typedef struct packed {
        logic        line_start;
        logic [3:0]  field_number;
        logic [2:0]  char_position;
        logic        header_match;
        logic [7:0]  xor_accumulator;
        logic        after_star;
        logic        star_seen;
        logic [7:0]  hex_received;
        logic [1:0]  hex_digit_count;
        logic        hex_overflow;
        logic [6:0]  utc_hour;
        logic [6:0]  minute_value;
        logic [6:0]  second_value;
        logic        time_digits_ok;
        logic        status_active;
        logic [14:0] longitude_integer;
        logic        in_fraction;
        logic        fraction_nonzero;
        logic        east_flag;
    } t_pstate;

    localparam t_pstate ST_RESET = '{
        line_start:     1'b1,
        header_match:   1'b1,
        time_digits_ok: 1'b1,
        default:        '0
    };

    typedef struct packed {
        logic        ok;
        logic [6:0]  utc_hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [14:0] lon_int;
        logic        lon_frac_nz;
        logic        east;
    } t_line;

endpackage

`default_nettype wire

@@ design/nmea_rmc_local_time_parser.sv @@
// Top level of the RMC local-time parser: input register, parser, hour shift
// and result register with the valid/stall handshakes.
// Depends on rmc_pkg, rmc_parse and rmc_hour.
`default_nettype none

// The block takes one sentence byte per cycle while o_stall is low and gives
// one result for each byte marked as end of line. Bytes enter an input register
// and are parsed from there, and the result of a finished sentence lands in an
// output register; a stalled result holds back only the end-of-line byte that
// follows it, so ordinary bytes keep flowing.
// A rejected sentence reports zero hour, minute and second.
module nmea_rmc_local_time_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_end_of_line,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_accepted,
    output logic [4:0]       o_local_hour,
    output logic [6:0]       o_minute,
    output logic [6:0]       o_second
);

    logic           r_in_valid;
    logic [7:0]     r_char;
    logic           r_eol;
    logic           r_out_valid;
    logic           r_acc;
    logic [4:0]     r_hour;
    logic [6:0]     r_min;
    logic [6:0]     r_sec;

    logic           out_free;
    logic           step;
    logic           in_take;
    rmc_pkg::t_line line;
    logic [4:0]     local_hour;

    assign out_free = !r_out_valid || !i_stall;
    assign step     = r_in_valid && (!r_eol || out_free);
    assign o_stall  = r_in_valid && !step;
    assign in_take  = i_valid && !o_stall;

    rmc_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_eol   (r_eol),
        .o_line  (line)
    );

    rmc_hour u_hour (
        .i_line       (line),
        .o_local_hour (local_hour)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_char_in;
            r_eol  <= i_end_of_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_eol) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_eol) begin
            r_acc  <= line.ok;
            r_hour <= line.ok ? local_hour : 5'd0;
            r_min  <= line.ok ? line.minute : 7'd0;
            r_sec  <= line.ok ? line.second : 7'd0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_accepted   = r_acc;
    assign o_local_hour = r_hour;
    assign o_minute     = r_min;
    assign o_second     = r_sec;

endmodule

`default_nettype wire

@@ design/rmc_parse.sv @@
// Per-byte sentence parser: holds the field, checksum and time-field state and
// produces the summary of a finished sentence.
// Depends on rmc_pkg.
`default_nettype none

module rmc_parse (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_eol,
    output rmc_pkg::t_line     o_line
);

    rmc_pkg::t_pstate r_st;
    rmc_pkg::t_pstate n_st;
    rmc_pkg::t_pstate upd;

    logic        digit;
    logic [3:0]  dv;
    logic        hex_ok;
    logic [3:0]  hex_nib;
    logic [17:0] lon_next;

    function automatic logic [7:0] header_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = rmc_pkg::CH_DOLLAR;
            3'd1:    c = rmc_pkg::CH_UPPER_G;
            3'd2:    c = rmc_pkg::CH_UPPER_P;
            3'd3:    c = rmc_pkg::CH_UPPER_R;
            3'd4:    c = rmc_pkg::CH_UPPER_M;
            default: c = rmc_pkg::CH_UPPER_C;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] mul10_add(input logic [6:0] x, input logic [3:0] d);
        logic [10:0] p;
        p = 11'({x, 3'b000}) + 11'({x, 1'b0}) + 11'(d);
        return p[6:0];
    endfunction

    always_comb begin
        digit   = (i_char >= rmc_pkg::CH_ZERO) && (i_char <= rmc_pkg::CH_NINE);
        dv      = digit ? 4'(i_char - rmc_pkg::CH_ZERO) : 4'd0;
        hex_ok  = 1'b1;
        hex_nib = 4'd0;
        if (digit) begin
            hex_nib = dv;
        end else if (i_char >= rmc_pkg::CH_UPPER_A && i_char <= rmc_pkg::CH_UPPER_F) begin
            hex_nib = 4'(i_char - rmc_pkg::CH_UPPER_A + 8'd10);
        end else if (i_char >= rmc_pkg::CH_LOWER_A && i_char <= rmc_pkg::CH_LOWER_F) begin
            hex_nib = 4'(i_char - rmc_pkg::CH_LOWER_A + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
        lon_next = 18'({r_st.longitude_integer, 3'b000})
                 + 18'({r_st.longitude_integer, 1'b0}) + 18'(dv);
    end

    always_comb begin
        upd = r_st;
        if (r_st.line_start) begin
            upd.line_start    = 1'b0;
            upd.header_match  = (i_char == rmc_pkg::CH_DOLLAR);
            upd.char_position = 3'd1;
        end else if (r_st.after_star) begin
            if (!hex_ok || r_st.hex_digit_count >= 2'd2) begin
                upd.hex_overflow = 1'b1;
            end else begin
                upd.hex_received    = {r_st.hex_received[3:0], hex_nib};
                upd.hex_digit_count = r_st.hex_digit_count + 2'd1;
            end
        end else if (i_char == rmc_pkg::CH_STAR) begin
            upd.after_star = 1'b1;
            upd.star_seen  = 1'b1;
        end else begin
            upd.xor_accumulator = r_st.xor_accumulator ^ i_char;
            if (i_char == rmc_pkg::CH_COMMA) begin
                if (r_st.field_number == rmc_pkg::FLD_HEADER && r_st.char_position != 3'd6) begin
                    upd.header_match = 1'b0;
                end
                if (r_st.field_number == rmc_pkg::FLD_TIME && r_st.char_position < 3'd6) begin
                    upd.time_digits_ok = 1'b0;
                end
                if (r_st.field_number != rmc_pkg::FLD_MAX) begin
                    upd.field_number = r_st.field_number + 4'd1;
                end
                upd.char_position = 3'd0;
            end else begin
                unique case (r_st.field_number)
                    rmc_pkg::FLD_HEADER: begin
                        if (r_st.char_position < 3'd6
                                && i_char != header_char(r_st.char_position)) begin
                            upd.header_match = 1'b0;
                        end
                    end
                    rmc_pkg::FLD_TIME: begin
                        if (r_st.char_position < 3'd6) begin
                            if (!digit) begin
                                upd.time_digits_ok = 1'b0;
                            end
                            if (r_st.char_position < 3'd2) begin
                                upd.utc_hour = mul10_add(r_st.utc_hour, dv);
                            end else if (r_st.char_position < 3'd4) begin
                                upd.minute_value = mul10_add(r_st.minute_value, dv);
                            end else begin
                                upd.second_value = mul10_add(r_st.second_value, dv);
                            end
                        end
                    end
                    rmc_pkg::FLD_STATUS: begin
                        upd.status_active = (r_st.char_position == 3'd0)
                                         && (i_char == rmc_pkg::CH_UPPER_A);
                    end
                    rmc_pkg::FLD_LON: begin
                        if (i_char == rmc_pkg::CH_DOT) begin
                            upd.in_fraction = 1'b1;
                        end else if (digit) begin
                            if (r_st.in_fraction) begin
                                if (dv != 4'd0) begin
                                    upd.fraction_nonzero = 1'b1;
                                end
                            end else if (lon_next > 18'(rmc_pkg::LON_MAX)) begin
                                upd.longitude_integer = 15'(rmc_pkg::LON_MAX);
                            end else begin
                                upd.longitude_integer = lon_next[14:0];
                            end
                        end
                    end
                    rmc_pkg::FLD_EW: begin
                        upd.east_flag = (r_st.char_position == 3'd0)
                                     && (i_char == rmc_pkg::CH_UPPER_E);
                    end
                    default: begin
                    end
                endcase
                if (r_st.char_position != 3'd7) begin
                    upd.char_position = r_st.char_position + 3'd1;
                end
            end
        end
    end

    always_comb begin
        n_st = r_st;
        if (i_step) begin
            n_st = i_eol ? rmc_pkg::ST_RESET : upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rmc_pkg::ST_RESET;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        o_line.ok = upd.header_match && upd.star_seen && !upd.hex_overflow
                 && (upd.xor_accumulator == upd.hex_received) && upd.status_active
                 && upd.time_digits_ok && (upd.field_number >= rmc_pkg::FLD_EW);
        o_line.utc_hour    = upd.utc_hour;
        o_line.minute      = upd.minute_value;
        o_line.second      = upd.second_value;
        o_line.lon_int     = upd.longitude_integer;
        o_line.lon_frac_nz = upd.fraction_nonzero;
        o_line.east        = upd.east_flag;
    end

endmodule

`default_nettype wire

@@ design/rmc_hour.sv @@
// Local hour from a sentence summary: longitude time-zone offset and the
// shift of the UTC hour modulo one day.
// Depends on rmc_pkg.
`default_nettype none

module rmc_hour (
    input  wire rmc_pkg::t_line  i_line,
    output logic [4:0]           o_local_hour
);

    localparam int unsigned ZONES = rmc_pkg::ZONE_MAX;

    logic [ZONES-1:0] above;
    logic [3:0]       zone;
    logic [7:0]       sum;
    logic [7:0]       sub;
    logic [7:0]       rem;

    always_comb begin
        for (int k = 0; k < ZONES; k++) begin
            above[k] = (i_line.lon_int > 15'(rmc_pkg::ZONE_HALF + rmc_pkg::ZONE_STEP * k))
                    || ((i_line.lon_int == 15'(rmc_pkg::ZONE_HALF + rmc_pkg::ZONE_STEP * k))
                        && i_line.lon_frac_nz);
        end
        zone = 4'($countones(above));
        if (i_line.east) begin
            sum = 8'(i_line.utc_hour) + 8'(rmc_pkg::HOURS_DAY) + 8'(zone);
        end else begin
            sum = 8'(i_line.utc_hour) + 8'(rmc_pkg::HOURS_DAY) - 8'(zone);
        end
        sub = 8'd0;
        for (int k = 1; k <= 5; k++) begin
            if (sum >= 8'(rmc_pkg::HOURS_DAY * k)) begin
                sub = 8'(rmc_pkg::HOURS_DAY * k);
            end
        end
        rem          = sum - sub;
        o_local_hour = rem[4:0];
    end

endmodule

`default_nettype wire

@@ design/rmc_checker.sv @@
// Port-level checks for the RMC local-time parser, attached to the top level
// by the bind statement at the end of this file.
// Depends on nmea_rmc_local_time_parser.
`default_nettype none

module rmc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_accepted,
    input wire logic [4:0]  o_local_hour,
    input wire logic [6:0]  o_minute,
    input wire logic [6:0]  o_second
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_accepted) && $stable(o_local_hour)
            && $stable(o_minute) && $stable(o_second))
        else $error("stalled result transaction changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> o_local_hour == 5'd0 && o_minute == 7'd0
            && o_second == 7'd0)
        else $error("rejected sentence reports nonzero time");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_local_hour < 5'd24)
        else $error("local hour out of range");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_minute <= 7'd99 && o_second <= 7'd99)
        else $error("minute or second out of decimal range");

endmodule

bind nmea_rmc_local_time_parser rmc_checker u_rmc_checker (.*);

`default_nettype wire

@@ tb/rmc_fix_checker.sv @@
`timescale 1ns / 1ps
// Checker for the RMC local-time parser: watches the byte and result channels,
// predicts every result with its own model of the parser and compares them.
// Depends on rmc_pkg.

module rmc_fix_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_line,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_accepted,
    input  logic [4:0] i_local_hour,
    input  logic [6:0] i_minute,
    input  logic [6:0] i_second,
    output int         o_error_count,
    output int         o_outstanding
);

    typedef struct packed {
        logic       accepted;
        logic [4:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } t_fix;

    localparam logic [47:0] HEADER_TEXT =
        {rmc_pkg::CH_DOLLAR, rmc_pkg::CH_UPPER_G, rmc_pkg::CH_UPPER_P,
         rmc_pkg::CH_UPPER_R, rmc_pkg::CH_UPPER_M, rmc_pkg::CH_UPPER_C};

    logic        at_line_start;
    logic [3:0]  field_idx;
    logic [2:0]  pos_in_field;
    logic        header_ok;
    logic [7:0]  running_xor;
    logic        in_checksum;
    logic        star_found;
    logic [7:0]  checksum_text;
    logic [1:0]  checksum_digits;
    logic        checksum_bad;
    logic [6:0]  hour_utc;
    logic [6:0]  min_utc;
    logic [6:0]  sec_utc;
    logic        time_ok;
    logic        status_ok;
    logic [14:0] lon_whole;
    logic        lon_in_frac;
    logic        lon_frac_nz;
    logic        is_east;

    t_fix expected_fixes[$];

    initial begin
        o_error_count = 0;
        o_outstanding = 0;
    end

    function automatic void clear_sentence();
        at_line_start   = 1'b1;
        field_idx       = '0;
        pos_in_field    = '0;
        header_ok       = 1'b1;
        running_xor     = '0;
        in_checksum     = 1'b0;
        star_found      = 1'b0;
        checksum_text   = '0;
        checksum_digits = '0;
        checksum_bad    = 1'b0;
        hour_utc        = '0;
        min_utc         = '0;
        sec_utc         = '0;
        time_ok         = 1'b1;
        status_ok       = 1'b0;
        lon_whole       = '0;
        lon_in_frac     = 1'b0;
        lon_frac_nz     = 1'b0;
        is_east         = 1'b0;
    endfunction

    task automatic flag_error(input string msg);
        $display("%0t rmc_fix_checker: %s", $time, msg);
        o_error_count++;
    endtask

    task automatic parse_sentence_byte(input logic [7:0] c, input logic eol);
        logic        is_digit;
        logic [3:0]  dv;
        int          nib;
        int unsigned wide;
        int unsigned zone;
        int unsigned hr;
        t_fix        fix;
        is_digit = (c >= rmc_pkg::CH_ZERO) && (c <= rmc_pkg::CH_NINE);
        dv = is_digit ? 4'(c - rmc_pkg::CH_ZERO) : 4'd0;
        if (at_line_start) begin
            at_line_start = 1'b0;
            header_ok = (c == rmc_pkg::CH_DOLLAR);
            pos_in_field = 3'd1;
        end else if (in_checksum) begin
            nib = -1;
            if (is_digit) begin
                nib = dv;
            end else if (c >= rmc_pkg::CH_UPPER_A && c <= rmc_pkg::CH_UPPER_F) begin
                nib = c - rmc_pkg::CH_UPPER_A + 10;
            end else if (c >= rmc_pkg::CH_LOWER_A && c <= rmc_pkg::CH_LOWER_F) begin
                nib = c - rmc_pkg::CH_LOWER_A + 10;
            end
            if (nib < 0 || checksum_digits >= 2'd2) begin
                checksum_bad = 1'b1;
            end else begin
                checksum_text = {checksum_text[3:0], 4'(nib)};
                checksum_digits++;
            end
        end else if (c == rmc_pkg::CH_STAR) begin
            in_checksum = 1'b1;
            star_found = 1'b1;
        end else begin
            running_xor ^= c;
            if (c == rmc_pkg::CH_COMMA) begin
                if (field_idx == rmc_pkg::FLD_HEADER && pos_in_field != 3'd6) header_ok = 1'b0;
                if (field_idx == rmc_pkg::FLD_TIME && pos_in_field < 3'd6) time_ok = 1'b0;
                if (field_idx != rmc_pkg::FLD_MAX) field_idx++;
                pos_in_field = '0;
            end else begin
                case (field_idx)
                    rmc_pkg::FLD_HEADER: begin
                        if (pos_in_field < 3'd6 && c != HEADER_TEXT[47 - 8*pos_in_field -: 8])
                            header_ok = 1'b0;
                    end
                    rmc_pkg::FLD_TIME: begin
                        if (pos_in_field < 3'd6) begin
                            if (!is_digit) time_ok = 1'b0;
                            if (pos_in_field < 3'd2) hour_utc = 7'(hour_utc * 10 + dv);
                            else if (pos_in_field < 3'd4) min_utc = 7'(min_utc * 10 + dv);
                            else sec_utc = 7'(sec_utc * 10 + dv);
                        end
                    end
                    rmc_pkg::FLD_STATUS:
                        status_ok = (pos_in_field == 3'd0) && (c == rmc_pkg::CH_UPPER_A);
                    rmc_pkg::FLD_LON: begin
                        if (c == rmc_pkg::CH_DOT) begin
                            lon_in_frac = 1'b1;
                        end else if (is_digit) begin
                            if (lon_in_frac) begin
                                if (dv != 4'd0) lon_frac_nz = 1'b1;
                            end else begin
                                wide = lon_whole * 10 + dv;
                                lon_whole = (wide > rmc_pkg::LON_MAX) ?
                                            15'(rmc_pkg::LON_MAX) : 15'(wide);
                            end
                        end
                    end
                    rmc_pkg::FLD_EW:
                        is_east = (pos_in_field == 3'd0) && (c == rmc_pkg::CH_UPPER_E);
                    default: ;
                endcase
                if (pos_in_field != 3'd7) pos_in_field++;
            end
        end
        if (eol) begin
            fix = '0;
            if (header_ok && star_found && !checksum_bad && running_xor == checksum_text &&
                status_ok && time_ok && field_idx >= rmc_pkg::FLD_EW) begin
                wide = lon_whole;
                if (wide < rmc_pkg::ZONE_HALF
                        || (wide == rmc_pkg::ZONE_HALF && !lon_frac_nz)) begin
                    zone = 0;
                end else begin
                    if (lon_frac_nz)
                        zone = (wide - rmc_pkg::ZONE_HALF) / rmc_pkg::ZONE_STEP + 1;
                    else
                        zone = (wide - rmc_pkg::ZONE_HALF + rmc_pkg::ZONE_STEP - 1)
                             / rmc_pkg::ZONE_STEP;
                    if (zone > rmc_pkg::ZONE_MAX) zone = rmc_pkg::ZONE_MAX;
                end
                hr = is_east ? hour_utc + rmc_pkg::HOURS_DAY + zone
                             : hour_utc + rmc_pkg::HOURS_DAY - zone;
                fix.accepted = 1'b1;
                fix.hour = 5'(hr % rmc_pkg::HOURS_DAY);
                fix.minute = min_utc;
                fix.second = sec_utc;
            end
            expected_fixes.push_back(fix);
            clear_sentence();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_fix want;
        if (!i_rst_n) begin
            clear_sentence();
            expected_fixes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_fixes.size() == 0) begin
                    flag_error("result transaction with no sentence pending");
                end else begin
                    want = expected_fixes.pop_front();
                    if (i_accepted !== want.accepted)
                        flag_error($sformatf("accepted %b, expected %b",
                                             i_accepted, want.accepted));
                    if (i_local_hour !== want.hour)
                        flag_error($sformatf("local hour %0d, expected %0d",
                                             i_local_hour, want.hour));
                    if (i_minute !== want.minute)
                        flag_error($sformatf("minute %0d, expected %0d",
                                             i_minute, want.minute));
                    if (i_second !== want.second)
                        flag_error($sformatf("second %0d, expected %0d",
                                             i_second, want.second));
                end
            end
            if (i_in_valid && !i_in_stall) parse_sentence_byte(i_char_in, i_end_of_line);
        end
        o_outstanding = expected_fixes.size();
    end

endmodule

@@ tb/nmea_rmc_local_time_parser_test.sv @@
`timescale 1ns / 1ps
// Top of the RMC local-time parser testbench: clock, reset, sentence stimulus
// in random bursts, result stalls and the final verdict.
// Depends on rmc_pkg, nmea_rmc_local_time_parser and rmc_fix_checker.

module nmea_rmc_local_time_parser_test;

    typedef enum int {
        CK_UPPER, CK_LOWER, CK_WRONG, CK_MISSING, CK_EMPTY,
        CK_ONE_DIGIT, CK_THREE_DIGITS, CK_JUNK
    } t_ck_form;

    typedef enum int {STALL_NONE, STALL_SOME, STALL_MOST} t_stall_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_char_in;
    logic       i_end_of_line;
    logic       o_valid;
    logic       i_stall;
    logic       o_accepted;
    logic [4:0] o_local_hour;
    logic [6:0] o_minute;
    logic [6:0] o_second;

    int error_count;
    int outstanding;

    logic [7:0]  line_bytes[$];
    int          burst_left = 0;
    int          sent_bytes = 0;
    int          random_lines = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    nmea_rmc_local_time_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_in     (i_char_in),
        .i_end_of_line (i_end_of_line),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_accepted    (o_accepted),
        .o_local_hour  (o_local_hour),
        .o_minute      (o_minute),
        .o_second      (o_second)
    );

    rmc_fix_checker u_fix_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_char_in     (i_char_in),
        .i_end_of_line (i_end_of_line),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_accepted    (o_accepted),
        .i_local_hour  (o_local_hour),
        .i_minute      (o_minute),
        .i_second      (o_second),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE: i_stall <= 1'b0;
            STALL_SOME: i_stall <= ($urandom_range(0, 3) == 0);
            default:    i_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] c, input logic eol);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        end
        burst_left--;
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_in <= c;
        i_end_of_line <= eol;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent_bytes++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
        line_bytes.delete();
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
    endtask

    task automatic put_digits(input int n);
        repeat (n) line_bytes.push_back(8'(rmc_pkg::CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic close_line(input t_ck_form form);
        logic [7:0] sum;
        string      junk;
        sum = '0;
        junk = " Gg*,z";
        for (int i = 1; i < line_bytes.size(); i++) sum ^= line_bytes[i];
        if (form == CK_EMPTY) begin
            line_bytes.push_back(rmc_pkg::CH_COMMA);
            sum ^= rmc_pkg::CH_COMMA;
            if (sum == rmc_pkg::CH_STAR || sum == rmc_pkg::CH_COMMA) begin
                line_bytes.push_back(rmc_pkg::CH_LOWER_A);
                sum ^= rmc_pkg::CH_LOWER_A;
            end
            if (sum != 8'd0) line_bytes.push_back(sum);
            sum = '0;
        end
        if (form != CK_MISSING) line_bytes.push_back(rmc_pkg::CH_STAR);
        case (form)
            CK_UPPER:        put_text($sformatf("%02X", sum));
            CK_LOWER:        put_text($sformatf("%02x", sum));
            CK_WRONG:        put_text($sformatf("%02X", sum ^ 8'($urandom_range(1, 255))));
            CK_ONE_DIGIT:    put_text($sformatf("%1X", sum[3:0]));
            CK_THREE_DIGITS: put_text($sformatf("0%02X", sum));
            CK_JUNK: begin
                put_text($sformatf("%1X", sum[7:4]));
                line_bytes.push_back(junk[$urandom_range(0, 5)]);
            end
            default: ;
        endcase
        send_line();
    endtask

    task automatic send_random_line();
        int lon;
        int pick;
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
            send_line();
            return;
        end
        case ($urandom_range(0, 39))
            0: put_text("$GPRMA");
            1: put_text("$GNRMC");
            2: put_text("$GPRM");
            3: put_text("$GPRMCC");
            4: begin
                line_bytes.push_back(8'($urandom_range(0, 255)));
                put_text("GPRMC");
            end
            default: put_text("$GPRMC");
        endcase
        put_text(",");
        case ($urandom_range(0, 19))
            0: put_digits($urandom_range(0, 5));
            1: begin
                put_digits(2);
                line_bytes.push_back(8'($urandom_range(0, 255)));
                put_digits(3);
            end
            default: begin
                put_digits(6);
                if ($urandom_range(0, 1) != 0) begin
                    put_text(".");
                    put_digits($urandom_range(1, 3));
                end
            end
        endcase
        put_text(",");
        case ($urandom_range(0, 23))
            0: put_text("V");
            1: ;
            2: put_text("AA");
            default: put_text("A");
        endcase
        put_text(",");
        put_digits(4);
        put_text(".");
        put_digits(3);
        put_text(($urandom_range(0, 1) != 0) ? ",N," : ",S,");
        if ($urandom_range(0, 19) == 0) begin
            close_line(CK_UPPER);
            return;
        end
        case ($urandom_range(0, 9))
            0: put_text($sformatf("%0d", $urandom_range(0, 9999999)));
            1, 2: begin
                lon = $urandom_range(0, 12) * rmc_pkg::ZONE_STEP + rmc_pkg::ZONE_HALF
                    + $urandom_range(0, 2) - 1;
                put_text($sformatf("%05d", lon));
                put_text(($urandom_range(0, 1) != 0) ? ".0000" : ".0001");
            end
            3: begin
                put_text($sformatf("%05d", $urandom_range(0, 18000)));
                put_text(".0.3x1");
            end
            default: begin
                put_text($sformatf("%05d", $urandom_range(0, 18000)));
                if ($urandom_range(0, 3) != 0) begin
                    put_text(".");
                    put_digits(4);
                end
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: put_text(",E");
            8: put_text(",");
            9: put_text(",EE");
            default: put_text(",W");
        endcase
        if ($urandom_range(0, 2) != 0) put_text(",022.4,084.4,230394,003.1,W,A");
        pick = $urandom_range(0, 29);
        case (pick)
            0: close_line(CK_WRONG);
            1: close_line(CK_MISSING);
            2: close_line(CK_EMPTY);
            3: close_line(CK_ONE_DIGIT);
            4: close_line(CK_THREE_DIGITS);
            5: close_line(CK_JUNK);
            default: close_line((pick % 2 != 0) ? CK_UPPER : CK_LOWER);
        endcase
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_char_in = '0;
        i_end_of_line = 1'b0;
        i_stall = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        put_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W");
        close_line(CK_UPPER);
        put_text("$GPRMC,235959,A,,,17959.9999,W");
        close_line(CK_LOWER);
        put_text("$GPRMC,000000,A,,,00750.0000,W");
        close_line(CK_UPPER);
        put_text("$GPRMC,000000,A,,,00750.0001,W");
        close_line(CK_UPPER);
        put_text("$GPRMC,101010,A,,,02250,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,995959,A,,,99999999.9.9x,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,000000,A,,,,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,123456,V,,,01500,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,123456,AA,,,01500,E");
        close_line(CK_UPPER);
        put_text("$GPRMB,123456,A,,,01500,E");
        close_line(CK_UPPER);
        put_text("$GPRMCX,123456,A,,,01500,E");
        close_line(CK_UPPER);
        put_text("!GPRMC,123456,A,,,01500,E");
        close_line(CK_UPPER);
        for (int f = CK_WRONG; f <= CK_JUNK; f++) begin
            put_text("$GPRMC,123456,A,,,01500,E");
            close_line(t_ck_form'(f));
        end
        put_text("$GPRMC,123456,A,,01500,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,12345,A,,,,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,12a456,A,,,,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,1234567.89,A,,,,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,123456,A,,,,e");
        close_line(CK_UPPER);
        line_bytes.push_back(rmc_pkg::CH_DOLLAR);
        send_line();
        put_text("*GPRMC,123456,A,,,,E");
        close_line(CK_UPPER);
        put_text("$GPRMC,123456,A,,,,E,,,,,,,,,,,,,,,,,,,");
        close_line(CK_UPPER);
        line_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        send_line();
        pause_until_drained();

        while (sent_bytes < 1100 || random_lines < 4) begin
            if (random_lines % 4 == 3) pause_until_drained();
            send_random_line();
            random_lines++;
        end
        pause_until_drained();
        repeat (8) @(negedge i_clk);

        if (error_count == 0) begin
            $display("nmea_rmc_local_time_parser_test: clean");
        end else begin
            $display("nmea_rmc_local_time_parser_test: errors");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("nmea_rmc_local_time_parser_test: errors");
        $finish;
    end

endmodule
